/* hw/rtl/cpr_pkg.sv */
`default_nettype none
package cpr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 18;
	localparam int COEF_XW = COEF_W + 1;
	localparam int STATE_W = 32;
	localparam int PROD_W = STATE_W + COEF_XW;
	localparam int PSUM_W = PROD_W + 1;
	localparam int SUM_W = PSUM_W + 1;

	localparam int COEF_FRAC_BITS = 16;
	localparam int STATE_FRAC_BITS = 8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_RE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_IM = 1'd1;

	typedef struct packed {
		logic signed [STATE_W-1:0] re;
		logic signed [STATE_W-1:0] im;
	} cplx_t;

	typedef struct packed {
		logic signed [COEF_XW-1:0] re;
		logic signed [COEF_XW-1:0] im;
		logic signed [COEF_XW-1:0] im_conj;
	} coef_t;

	function automatic logic signed [STATE_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(STATE_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			sat = hi[STATE_W-1:0];
		end else if (v < lo) begin
			sat = lo[STATE_W-1:0];
		end else begin
			sat = v[STATE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpr_if.sv */
`default_nettype none
interface cpr_smp_if;
	logic valid;
	logic ready;
	logic signed [cpr_pkg::SAMPLE_W-1:0] sample_re;
	logic signed [cpr_pkg::SAMPLE_W-1:0] sample_im;

	modport source (output valid, output sample_re, output sample_im, input ready);
	modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

interface cpr_res_if;
	logic valid;
	logic ready;
	logic signed [cpr_pkg::STATE_W-1:0] out_re;
	logic signed [cpr_pkg::STATE_W-1:0] out_im;

	modport source (output valid, output out_re, output out_im, input ready);
	modport sink (input valid, input out_re, input out_im, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cpr_cfg.sv */
`default_nettype none
module cpr_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [cpr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [cpr_pkg::COEF_W-1:0] cfg_data,
	output cpr_pkg::coef_t coef
);

	logic signed [cpr_pkg::COEF_W-1:0] coef_re_q;
	logic signed [cpr_pkg::COEF_W-1:0] coef_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_re_q <= '0;
			coef_im_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				cpr_pkg::REG_COEF_RE: coef_re_q <= cfg_data;
				cpr_pkg::REG_COEF_IM: coef_im_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one extra bit so the conjugate of the most negative value stays exact
	always_comb begin
		coef.re = cpr_pkg::COEF_XW'(coef_re_q);
		coef.im = cpr_pkg::COEF_XW'(coef_im_q);
		coef.im_conj = -cpr_pkg::COEF_XW'(coef_im_q);
	end

endmodule
`default_nettype wire

/* hw/rtl/cpr_section.sv */
`default_nettype none
module cpr_section #(
	parameter int COEF_FRAC_BITS = cpr_pkg::COEF_FRAC_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic signed [cpr_pkg::COEF_XW-1:0] c_re,
	input wire logic signed [cpr_pkg::COEF_XW-1:0] c_im,
	input wire cpr_pkg::cplx_t x,
	output cpr_pkg::cplx_t nxt,
	output cpr_pkg::cplx_t st
);

	localparam logic signed [cpr_pkg::PSUM_W-1:0] RND =
		cpr_pkg::PSUM_W'(1) <<< (COEF_FRAC_BITS - 1);

	cpr_pkg::cplx_t st_q;
	logic signed [cpr_pkg::PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
	logic signed [cpr_pkg::PSUM_W-1:0] acc_re, acc_im, rnd_re, rnd_im;

	always_comb begin
		p_rr = st_q.re * c_re;
		p_ii = st_q.im * c_im;
		p_ri = st_q.re * c_im;
		p_ir = st_q.im * c_re;
		acc_re = cpr_pkg::PSUM_W'(p_rr) - cpr_pkg::PSUM_W'(p_ii);
		acc_im = cpr_pkg::PSUM_W'(p_ri) + cpr_pkg::PSUM_W'(p_ir);
		// round half up, floor shift
		rnd_re = (acc_re + RND) >>> COEF_FRAC_BITS;
		rnd_im = (acc_im + RND) >>> COEF_FRAC_BITS;
		nxt.re = cpr_pkg::sat(cpr_pkg::SUM_W'(rnd_re) + cpr_pkg::SUM_W'(x.re));
		nxt.im = cpr_pkg::sat(cpr_pkg::SUM_W'(rnd_im) + cpr_pkg::SUM_W'(x.im));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= nxt;
		end
	end

	assign st = st_q;

endmodule
`default_nettype wire

/* hw/rtl/complex_two_pole_resonator.sv */
`default_nettype none
// Complex conjugate pole pair resonator: each complex sample goes through a one-pole
// section with coefficient c and then one with conj(c); the result is the second
// section's new state (8 fractional bits by default, saturated to 32 bits). One item
// is taken per clock cycle; its result is valid once it has passed the input register
// and then the result register, and a result held back by the sink stalls the input
// register. The clock limit is the state feedback path: the first section's four 32x19
// multiplies, rounding and saturation feed the second section's add and saturation with
// no register between them. Coefficients are written through the cfg port; the user must
// write them only while no item is in flight, which the block itself does not enforce.
module complex_two_pole_resonator #(
	parameter int COEF_FRAC_BITS = cpr_pkg::COEF_FRAC_BITS,
	parameter int STATE_FRAC_BITS = cpr_pkg::STATE_FRAC_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	cpr_smp_if.sink sample,
	cpr_res_if.source result,
	input wire logic cfg_we,
	input wire logic [cpr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [cpr_pkg::COEF_W-1:0] cfg_data
);

	logic valid_s1;
	logic signed [cpr_pkg::SAMPLE_W-1:0] sample_re_s1, sample_im_s1;
	logic res_valid_q;
	cpr_pkg::cplx_t res_q;
	logic adv;
	cpr_pkg::coef_t coef;
	cpr_pkg::cplx_t x1, nxt1, nxt2, st1, st2;

	cpr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.coef(coef)
	);

	assign adv = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			sample_re_s1 <= sample.sample_re;
			sample_im_s1 <= sample.sample_im;
		end
	end

	always_comb begin
		x1.re = cpr_pkg::STATE_W'(sample_re_s1) <<< STATE_FRAC_BITS;
		x1.im = cpr_pkg::STATE_W'(sample_im_s1) <<< STATE_FRAC_BITS;
	end

	cpr_section #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sec1 (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.c_re(coef.re),
		.c_im(coef.im),
		.x(x1),
		.nxt(nxt1),
		.st(st1)
	);

	cpr_section #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sec2 (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.c_re(coef.re),
		.c_im(coef.im_conj),
		.x(nxt1),
		.nxt(nxt2),
		.st(st2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= nxt2;
		end
	end

	assign result.valid = res_valid_q;
	assign result.out_re = res_q.re;
	assign result.out_im = res_q.im;

`ifndef SYNTHESIS
	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample.ready)
		else $error("input stage empty but not ready");
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_q && res_q == st2)
		else $error("result does not match second section state");
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st1) && $stable(st2))
		else $error("section state changed without an item");
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> st1 == $past(nxt1))
		else $error("first section state not updated");
`endif

endmodule
`default_nettype wire
